/* design/psvd_pkg.sv */
// shared types and constants for the program stream video demultiplexer
// no dependencies
package psvd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W  = 17;

	localparam logic [BYTE_W-1:0] ID_PACK     = 8'hBA;
	localparam logic [BYTE_W-1:0] ID_SYS_HDR  = 8'hBB;
	localparam logic [BYTE_W-1:0] ID_PRIV_1   = 8'hBC;
	localparam logic [BYTE_W-1:0] ID_PRIV_2   = 8'hBD;
	localparam logic [BYTE_W-1:0] VID_ID_RST  = 8'hE0;

	localparam logic [23:0]      START_CODE   = 24'h000001;
	localparam logic [POS_W-1:0] PACK_BASE    = 17'd14;
	localparam logic [POS_W-1:0] PACK_LAST_HDR = 17'd13;
	localparam logic [POS_W-1:0] LEN_HI_POS   = 17'd4;
	localparam logic [POS_W-1:0] PES_FIXED    = 17'd6;
	localparam logic [POS_W-1:0] HDR_LEN_POS  = 17'd8;
	localparam logic [POS_W-1:0] PAYLOAD_BASE = 17'd9;
	localparam logic [POS_W-1:0] ID_POS       = 17'd4;
	localparam logic [POS_W-1:0] WINDOW_FULL  = 17'd3;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              first;
		logic              last;
	} psvd_result_t;

endpackage

/* design/psvd_parser.sv */
// byte-wise stream parser: start-code hunt, header skipping, payload marking
// depends on psvd_pkg
module psvd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [psvd_pkg::BYTE_W-1:0]  in_byte,
	input  logic [psvd_pkg::BYTE_W-1:0]  video_id,
	output psvd_pkg::psvd_result_t       result
);
	import psvd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_PACK,
		PH_SKIP,
		PH_SYSLEN,
		PH_VIDLEN,
		PH_VIDHDR,
		PH_PAYLOAD
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [23:0]        recent_q, recent_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [POS_W-1:0]   total_q, total_d;
	logic [BYTE_W-1:0]  extra_q, extra_d;

	logic [POS_W-1:0]   pos_inc;
	logic [POS_W-1:0]   pack_total;
	logic [POS_W-1:0]   len_sum;
	logic [POS_W-1:0]   pay_start;
	logic               is_sys;
	logic               id_hit;

	assign pos_inc    = pos_q + 17'd1;
	assign pack_total = PACK_BASE + {14'd0, in_byte[2:0]};
	assign len_sum    = PES_FIXED + total_q + {9'd0, in_byte};
	assign pay_start  = PAYLOAD_BASE + {9'd0, extra_q};
	assign is_sys     = (in_byte == ID_SYS_HDR) || (in_byte == ID_PRIV_1) ||
		(in_byte == ID_PRIV_2);
	assign id_hit     = (in_byte == ID_PACK) || is_sys || (in_byte == video_id);

	always_comb begin
		phase_d      = phase_q;
		recent_d     = recent_q;
		pos_d        = pos_q;
		total_d      = total_q;
		extra_d      = extra_q;
		result.valid = 1'b0;
		result.data  = in_byte;
		result.first = 1'b0;
		result.last  = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (pos_q >= WINDOW_FULL && recent_q == START_CODE && id_hit) begin
					if (in_byte == ID_PACK)
						phase_d = PH_PACK;
					else if (is_sys)
						phase_d = PH_SYSLEN;
					else
						phase_d = PH_VIDLEN;
					pos_d    = ID_POS;
					recent_d = '0;
					total_d  = '0;
					extra_d  = '0;
				end else begin
					recent_d = {recent_q[15:0], in_byte};
					if (pos_q < WINDOW_FULL)
						pos_d = pos_inc;
				end
			end
			PH_PACK: begin
				pos_d = pos_inc;
				if (pos_q >= PACK_LAST_HDR) begin
					total_d = pack_total;
					if (pos_inc >= pack_total) begin
						phase_d  = PH_HUNT;
						recent_d = '0;
						pos_d    = '0;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				pos_d = pos_inc;
				if (pos_inc >= total_q) begin
					phase_d  = PH_HUNT;
					recent_d = '0;
					pos_d    = '0;
				end
			end
			PH_SYSLEN, PH_VIDLEN: begin
				pos_d = pos_inc;
				if (pos_q == LEN_HI_POS) begin
					total_d = {1'b0, in_byte, 8'h00};
				end else begin
					total_d = len_sum;
					if (len_sum <= PES_FIXED) begin
						phase_d  = PH_HUNT;
						recent_d = '0;
						pos_d    = '0;
					end else if (phase_q == PH_SYSLEN) begin
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_VIDHDR;
					end
				end
			end
			PH_VIDHDR: begin
				pos_d = pos_inc;
				if (pos_q == HDR_LEN_POS)
					extra_d = in_byte;
				if (pos_inc >= total_q) begin
					phase_d  = PH_HUNT;
					recent_d = '0;
					pos_d    = '0;
				end else if (pos_q == HDR_LEN_POS) begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				pos_d = pos_inc;
				if (pos_q >= pay_start) begin
					result.valid = 1'b1;
					result.first = (pos_q == pay_start);
					result.last  = (pos_inc == total_q);
				end
				if (pos_inc >= total_q) begin
					phase_d  = PH_HUNT;
					recent_d = '0;
					pos_d    = '0;
				end
			end
			default: begin
				phase_d  = PH_HUNT;
				recent_d = '0;
				pos_d    = '0;
			end
		endcase
		if (!step)
			result.valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			recent_q <= '0;
			pos_q    <= '0;
			total_q  <= '0;
			extra_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			recent_q <= recent_d;
			pos_q    <= pos_d;
			total_q  <= total_d;
			extra_q  <= extra_d;
		end
	end

endmodule

/* design/program_stream_video_demux_core.sv */
// a stream beat is first held in the input register; when the parser steps on it, its payload
// beat is captured in the result register, from which the receiver takes it
// throughput: one stream byte per cycle while the output side keeps taking beats
// input register, parser state update and result register form the only path
// reset: asynchronous active low; parser back to start-code hunt, window empty,
// video stream id back to 0xe0, no beats held
module program_stream_video_demux_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [psvd_pkg::BYTE_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [psvd_pkg::BYTE_W-1:0]  stream_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [psvd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                         first_of_payload,
	output logic                         last_of_payload
);
	import psvd_pkg::*;

	logic [BYTE_W-1:0] video_id_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] payload_q;
	logic              first_q;
	logic              last_q;
	logic              advance;
	psvd_result_t      res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			video_id_q <= VID_ID_RST;
		else if (cfg_we)
			video_id_q <= cfg_wdata;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= stream_byte;
	end

	psvd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.in_byte  (byte_s1),
		.video_id (video_id_q),
		.result   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= res.valid;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			payload_q <= res.data;
			first_q   <= res.first;
			last_q    <= res.last;
		end
	end

	assign out_valid        = out_valid_q;
	assign payload_byte     = payload_q;
	assign first_of_payload = first_q;
	assign last_of_payload  = last_q;

endmodule

/* tb/tb_program_stream_video_demux_core.sv */
// testbench for program_stream_video_demux_core: random and hand-built program streams
// are driven and every payload beat is checked against a built-in parser model
// depends on psvd_pkg and the core
`timescale 1ns / 1ps

module tb_program_stream_video_demux_core;
	import psvd_pkg::*;

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_PACK,
		PH_SKIP,
		PH_SYSLEN,
		PH_VIDLEN,
		PH_VIDHDR,
		PH_PAYLOAD
	} demux_phase_t;

	class payload_scoreboard;
		demux_phase_t       phase;
		logic [23:0]        window;
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   total;
		logic [BYTE_W-1:0]  hdr_len;
		logic [BYTE_W-1:0]  vid_id;
		psvd_result_t       expected_q[$];
		int unsigned        errors;
		int unsigned        noted;
		int unsigned        checked;

		function new();
			phase = PH_HUNT;
			window = '0;
			pos = '0;
			total = '0;
			hdr_len = '0;
			vid_id = VID_ID_RST;
			errors = 0;
			noted = 0;
			checked = 0;
		endfunction

		function void set_video_id(logic [BYTE_W-1:0] v);
			vid_id = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void close_packet();
			phase = PH_HUNT;
			window = '0;
			pos = '0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		// advance the parser by one accepted stream beat
		function void note_input(logic [BYTE_W-1:0] b);
			logic [POS_W-1:0] idx;
			logic [POS_W-1:0] start;
			psvd_result_t     r;
			idx = pos;
			noted++;
			case (phase)
				PH_HUNT: begin
					if (pos >= WINDOW_FULL && window == START_CODE &&
					    (b == ID_PACK || b == ID_SYS_HDR || b == ID_PRIV_1 ||
					     b == ID_PRIV_2 || b == vid_id)) begin
						if (b == ID_PACK)
							phase = PH_PACK;
						else if (b >= ID_SYS_HDR && b <= ID_PRIV_2)
							phase = PH_SYSLEN;
						else
							phase = PH_VIDLEN;
						pos = ID_POS;
						window = '0;
						total = '0;
						hdr_len = '0;
					end else begin
						window = {window[15:0], b};
						if (pos < WINDOW_FULL)
							pos = pos + 17'd1;
					end
				end
				PH_PACK: begin
					pos = idx + 17'd1;
					if (idx >= PACK_LAST_HDR) begin
						total = PACK_BASE + {14'd0, b[2:0]};
						if (pos >= total)
							close_packet();
						else
							phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					pos = idx + 17'd1;
					if (pos >= total)
						close_packet();
				end
				PH_SYSLEN, PH_VIDLEN: begin
					pos = idx + 17'd1;
					if (idx == LEN_HI_POS) begin
						total = {1'b0, b, 8'h00};
					end else begin
						total = PES_FIXED + total + {9'd0, b};
						if (total <= PES_FIXED)
							close_packet();
						else
							phase = (phase == PH_SYSLEN) ? PH_SKIP : PH_VIDHDR;
					end
				end
				PH_VIDHDR: begin
					pos = idx + 17'd1;
					if (idx == HDR_LEN_POS)
						hdr_len = b;
					if (pos >= total)
						close_packet();
					else if (idx == HDR_LEN_POS)
						phase = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					start = PAYLOAD_BASE + {9'd0, hdr_len};
					pos = idx + 17'd1;
					if (idx >= start) begin
						r.valid = 1'b1;
						r.data = b;
						r.first = (idx == start);
						r.last = (pos == total);
						expected_q.push_back(r);
					end
					if (pos >= total)
						close_packet();
				end
				default: close_packet();
			endcase
		endfunction

		task check_result(logic [BYTE_W-1:0] data, logic first, logic last);
			psvd_result_t exp_beat;
			checked++;
			if (expected_q.size() == 0) begin
				report($sformatf("payload beat %02h with nothing expected", data));
				return;
			end
			exp_beat = expected_q.pop_front();
			if (data !== exp_beat.data)
				report($sformatf("payload_byte %02h, expected %02h", data, exp_beat.data));
			if (first !== exp_beat.first)
				report($sformatf("first_of_payload %b, expected %b on byte %02h",
					first, exp_beat.first, exp_beat.data));
			if (last !== exp_beat.last)
				report($sformatf("last_of_payload %b, expected %b on byte %02h",
					last, exp_beat.last, exp_beat.data));
		endtask
	endclass

	// directed stream: zero-length private stream, start code over an emptied window,
	// single-packet payload with byte extremes, unknown id, packet ending before byte 8
	localparam int DIR_LEN = 31;
	localparam logic [DIR_LEN*8-1:0] DIRECTED_SEQ = {
		8'h00, 8'h00, 8'h01, 8'hBD, 8'h00, 8'h00,
		8'h01, 8'hE0,
		8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h05, 8'h80, 8'h80, 8'h00, 8'h00, 8'hFF,
		8'h00, 8'h00, 8'h01, 8'hC5,
		8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h02, 8'h80, 8'h80
	};
	// register value per phase, index 0 is the reset value
	localparam logic [8*8-1:0] PHASE_IDS = {
		8'hEF, 8'hD7, 8'hE0, 8'h3A, 8'hBB, 8'hEF, 8'hC0, 8'hE0
	};
	localparam int NUM_PHASES = 8;
	localparam int PHASE_BYTES = 120;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] stream_byte;
	logic              out_valid;
	logic              out_ready;
	logic [BYTE_W-1:0] payload_byte;
	logic              first_of_payload;
	logic              last_of_payload;

	payload_scoreboard sb;
	logic [BYTE_W-1:0] stim_q[$];
	logic [BYTE_W-1:0] cur_vid;
	int                send_idle;
	int                recv_stall;
	int                reg_writes;

	program_stream_video_demux_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.stream_byte      (stream_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.payload_byte     (payload_byte),
		.first_of_payload (first_of_payload),
		.last_of_payload  (last_of_payload)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(stream_byte);
			if (out_valid && out_ready)
				sb.check_result(payload_byte, first_of_payload, last_of_payload);
		end
	end

	// bytes that now and then form start-code fragments
	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 15))
			0, 1:    return 8'h00;
			2:       return 8'h01;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_start(input logic [BYTE_W-1:0] id);
		stim_q.push_back(8'h00);
		stim_q.push_back(8'h00);
		stim_q.push_back(8'h01);
		stim_q.push_back(id);
	endtask

	// video pes with given header-data length and length field, first keep body bytes
	task automatic queue_video(input int hdr, input int len, input int keep);
		push_start(cur_vid);
		stim_q.push_back(len[15:8]);
		stim_q.push_back(len[7:0]);
		for (int k = 0; k < keep; k++) begin
			if (k == 2)
				stim_q.push_back(hdr[7:0]);
			else
				stim_q.push_back(rand_byte());
		end
	endtask

	task automatic queue_random_unit();
		int kind;
		int hdr;
		int len;
		int stuff;
		logic [BYTE_W-1:0] oid;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			hdr = $urandom_range(0, 3);
			len = 3 + hdr + $urandom_range(1, 10);
			if ($urandom_range(0, 7) == 0) begin
				hdr = $urandom_range(1, 40);
				len = $urandom_range(3, 3 + hdr);
			end else if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(0, 2);
			end else if ($urandom_range(0, 19) == 0) begin
				hdr = $urandom_range(200, 255);
				len = hdr + $urandom_range(4, 6);
			end
			if (kind < 6)
				queue_video(hdr, len, $urandom_range(0, len));
			else
				queue_video(hdr, len, len);
		end else if (kind < 58) begin
			push_start(ID_PACK);
			repeat (9) stim_q.push_back(rand_byte());
			stuff = $urandom_range(0, 7);
			stim_q.push_back((rand_byte() & 8'hF8) | {5'd0, stuff[2:0]});
			repeat (stuff) stim_q.push_back(rand_byte());
		end else if (kind < 72) begin
			push_start(ID_SYS_HDR + 8'($urandom_range(0, 2)));
			len = $urandom_range(0, 8);
			stim_q.push_back(8'h00);
			stim_q.push_back(len[7:0]);
			repeat (len) stim_q.push_back(rand_byte());
		end else if (kind < 82) begin
			oid = 8'($urandom_range(8'hC0, 8'hEF));
			if (oid == cur_vid)
				oid = oid ^ 8'h01;
			push_start(oid);
			len = $urandom_range(0, 6);
			stim_q.push_back(8'h00);
			stim_q.push_back(len[7:0]);
			repeat (len) stim_q.push_back(rand_byte());
		end else begin
			repeat ($urandom_range(1, 6)) stim_q.push_back(rand_byte());
		end
	endtask

	task automatic drive_stream();
		forever begin
			@(posedge clk);
			if (!in_valid || in_ready) begin
				if (stim_q.size() == 0) begin
					in_valid <= 1'b0;
					break;
				end else if ($urandom_range(0, 99) < send_idle) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					stream_byte <= stim_q.pop_front();
				end
			end
		end
	endtask

	task automatic wait_quiet();
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_video_id(input logic [BYTE_W-1:0] v);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_video_id(v);
		cur_vid = v;
		reg_writes++;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		stream_byte = '0;
		cur_vid = VID_ID_RST;
		send_idle = 0;
		recv_stall = 0;
		reg_writes = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0)
				write_video_id(PHASE_IDS[ph*8 +: 8]);
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 76; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 76; end
				default: begin send_idle = 28; recv_stall = 28; end
			endcase
			if (ph == 0) begin
				for (int k = DIR_LEN - 1; k >= 0; k--)
					stim_q.push_back(DIRECTED_SEQ[k*8 +: 8]);
			end
			while (stim_q.size() < PHASE_BYTES)
				queue_random_unit();
			// a packet at the largest length field, cut short at the end of the run
			if (ph == NUM_PHASES - 1)
				queue_video(0, 16'hFFFF, 40);
			drive_stream();
		end

		@(posedge clk);
		for (int guard = 0; guard < 200000 && sb.pending() > 0; guard++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d payload beats never arrived", sb.pending()));

		$display("run covered %0d stream beats and %0d payload beats over %0d register settings",
			sb.noted, sb.checked, reg_writes + 1);
		$display("idle modes: none, sender idle, receiver stall, both; %0d mismatches",
			sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout with %0d payload beats outstanding", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule
